[hdl/dsam_pkg.sv]
// Shared types and constants of the diode safe-area monitor.
package dsam_pkg;

   localparam int unsigned MAX_WARNS_DEFAULT = 5;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORWARD_VOLT_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSE_VOLT_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURRENT_LIMIT      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWER_LIMIT        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMP_LIMIT         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOMINAL_TEMP       = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERATE_SLOPE       = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMITS_GIVEN       = 3'd7;

   // Item operation codes.
   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
   localparam logic signed [31:0] SMAX32 = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic               op;
      logic signed [31:0] terminal_voltage;
      logic signed [31:0] junction_current;
      logic signed [31:0] junction_voltage;
      logic        [30:0] series_conductance;
      logic               self_heating;
      logic signed [31:0] device_temp;
   } req_payload_type;

   typedef struct packed {
      logic        forward_warn;
      logic        reverse_warn;
      logic        current_warn;
      logic        power_warn;
      logic        temp_warn;
      logic [30:0] power_value;
      logic [30:0] derated_limit;
   } rsp_payload_type;

endpackage

[hdl/dsam_stream_if.sv]
// Valid/ready channel carrying one item per handshake.
interface dsam_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/diode_safe_area_monitor.sv]
// Top level of the diode safe-area monitor.
//
// Each check item occupies the block from acceptance to the next possible
// acceptance: the states of the one shared 33x33 signed multiplier (i*v,
// |i|*|i|, temperature excess times slope), a restoring divider that forms
// |i|^2/g one quotient bit per cycle, a final state that combines, checks and
// updates the warning counters, and the idle state in which the next item is
// accepted. A clear item passes from idle straight to the final state.
// Input ready is high only while the sequencer is idle; the result sits in
// an output register, and if it has not been taken when the next result is
// due, the sequencer waits in its final state.
module diode_safe_area_monitor
   import dsam_pkg::*;
#(
   parameter int unsigned MAX_WARNS = MAX_WARNS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   dsam_stream_if.sink                req_if,
   dsam_stream_if.source              rsp_if,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam logic [2:0] WARN_LIMIT = (MAX_WARNS < 7) ? 3'(MAX_WARNS) : 3'd7;
   localparam int unsigned DIV_STEPS = 47;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_IV = 3'd1;
   localparam logic [2:0] ST_MUL_II = 3'd2;
   localparam logic [2:0] ST_MUL_DT = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam int unsigned K_FWD = 0;
   localparam int unsigned K_REV = 1;
   localparam int unsigned K_CUR = 2;
   localparam int unsigned K_PWR = 3;
   localparam int unsigned K_TMP = 4;

   // Configuration registers.
   logic signed [31:0] fwd_lim_ff, rev_lim_ff, t_lim_ff, t_nom_ff;
   logic        [30:0] cur_lim_ff, pwr_lim_ff, slope_ff;
   logic        [1:0]  given_ff;

   // Sequencer and item registers.
   logic [2:0]          state_ff, state_in;
   logic                op_ff;
   logic signed [31:0]  vd_ff, i_ff, v_ff, te_ff;
   logic        [30:0]  g_ff;
   logic                sh_ff;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [47:0]  fl_ff, fl_in;
   logic        [30:0]  rem_ff, rem_in;
   logic        [46:0]  dq_ff, dq_in;
   logic                qbig_ff, qbig_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic        [30:0]  lim_ff, lim_in;
   logic [2:0]          warn_cnt_ff [5];
   logic [2:0]          warn_cnt_in [5];
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                accept;
   logic                deliver;
   logic [31:0]         abs_i;
   logic signed [32:0]  temp_diff;
   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   logic [31:0]         rem_shift;
   logic [47:0]         dec;
   logic                derate_on;
   logic                thermal_case;
   logic signed [48:0]  sum;
   logic [48:0]         mag;
   logic [30:0]         pwr_val;
   logic [4:0]          cond;
   logic [4:0]          hit;

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign accept         = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;
   assign deliver        = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   assign abs_i     = i_ff[31] ? 32'(-i_ff) : 32'(i_ff);
   assign temp_diff = 33'(te_ff) - 33'(t_nom_ff);

   // The one shared multiplier; its operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_MUL_IV: begin
            mul_a = 33'(i_ff);
            mul_b = 33'(v_ff);
         end
         ST_MUL_II: begin
            mul_a = $signed({1'b0, abs_i});
            mul_b = $signed({1'b0, abs_i});
         end
         ST_MUL_DT: begin
            mul_a = temp_diff;
            mul_b = $signed({2'b00, slope_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Divider step: shift the next dividend bit into the remainder.
   assign rem_shift = {rem_ff, dq_ff[46]};

   assign thermal_case = sh_ff && given_ff[0] && given_ff[1];
   assign derate_on    = thermal_case || (!sh_ff && given_ff[0]);
   assign dec          = prod_ff[63:16];

   // Power is |floor(i*v/2^16) + floor(i*i/g)|, saturated.
   assign sum     = 49'(fl_ff) + $signed({2'b00, dq_ff});
   assign mag     = sum[48] ? 49'(-sum) : 49'(sum);
   assign pwr_val = (qbig_ff || (mag > 49'(SAT31))) ? SAT31 : mag[30:0];

   assign cond[K_FWD] = vd_ff > fwd_lim_ff;
   assign cond[K_REV] = (-33'(vd_ff)) > 33'(rev_lim_ff);
   assign cond[K_CUR] = abs_i > {1'b0, cur_lim_ff};
   assign cond[K_PWR] = pwr_val > lim_ff;
   assign cond[K_TMP] = thermal_case && (te_ff > t_lim_ff);

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         hit[k] = cond[k] && (warn_cnt_ff[k] < WARN_LIMIT);
      end
   end

   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      fl_in        = fl_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      qbig_in      = qbig_ff;
      step_in      = step_ff;
      lim_in       = lim_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      for (int k = 0; k < 5; k++) begin
         warn_cnt_in[k] = warn_cnt_ff[k];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_if.payload.op == OP_CLEAR) ? ST_FINISH : ST_MUL_IV;
            end
         end
         ST_MUL_IV: begin
            prod_in  = mul_p[63:0];
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            fl_in    = prod_ff[63:16];
            prod_in  = mul_p[63:0];
            state_in = ST_MUL_DT;
         end
         ST_MUL_DT: begin
            // A quotient of 2^47 or more saturates the power whatever i*v is.
            rem_in   = {15'd0, prod_ff[62:47]};
            dq_in    = prod_ff[46:0];
            qbig_in  = {15'd0, prod_ff[62:47]} >= g_ff;
            step_in  = STEP_W'(DIV_STEPS - 1);
            prod_in  = mul_p[63:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_shift >= {1'b0, g_ff}) begin
               rem_in = 31'(rem_shift - {1'b0, g_ff});
               dq_in  = {dq_ff[45:0], 1'b1};
            end else begin
               rem_in = rem_shift[30:0];
               dq_in  = {dq_ff[45:0], 1'b0};
            end
            if (!derate_on || temp_diff[32]) begin
               lim_in = pwr_lim_ff;
            end else if (dec >= {17'd0, pwr_lim_ff}) begin
               lim_in = '0;
            end else begin
               lim_in = 31'({17'd0, pwr_lim_ff} - dec);
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (deliver) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_CLEAR) begin
                  rsp_data_in = '0;
                  for (int k = 0; k < 5; k++) begin
                     warn_cnt_in[k] = '0;
                  end
               end else begin
                  rsp_data_in.forward_warn  = hit[K_FWD];
                  rsp_data_in.reverse_warn  = hit[K_REV];
                  rsp_data_in.current_warn  = hit[K_CUR];
                  rsp_data_in.power_warn    = hit[K_PWR];
                  rsp_data_in.temp_warn     = hit[K_TMP];
                  rsp_data_in.power_value   = pwr_val;
                  rsp_data_in.derated_limit = lim_ff;
                  for (int k = 0; k < 5; k++) begin
                     warn_cnt_in[k] = warn_cnt_ff[k] + 3'(hit[k]);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 5; k++) begin
            warn_cnt_ff[k] <= '0;
         end
         fwd_lim_ff <= SMAX32;
         rev_lim_ff <= SMAX32;
         cur_lim_ff <= SAT31;
         pwr_lim_ff <= SAT31;
         t_lim_ff   <= SMAX32;
         t_nom_ff   <= '0;
         slope_ff   <= '0;
         given_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 5; k++) begin
            warn_cnt_ff[k] <= warn_cnt_in[k];
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FORWARD_VOLT_LIMIT: fwd_lim_ff <= $signed(csr_wr_data);
               CSR_REVERSE_VOLT_LIMIT: rev_lim_ff <= $signed(csr_wr_data);
               CSR_CURRENT_LIMIT:      cur_lim_ff <= csr_wr_data[30:0];
               CSR_POWER_LIMIT:        pwr_lim_ff <= csr_wr_data[30:0];
               CSR_TEMP_LIMIT:         t_lim_ff   <= $signed(csr_wr_data);
               CSR_NOMINAL_TEMP:       t_nom_ff   <= $signed(csr_wr_data);
               CSR_DERATE_SLOPE:       slope_ff   <= csr_wr_data[30:0];
               CSR_LIMITS_GIVEN:       given_ff   <= csr_wr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_if.payload.op;
         vd_ff <= req_if.payload.terminal_voltage;
         i_ff  <= req_if.payload.junction_current;
         v_ff  <= req_if.payload.junction_voltage;
         // A zero conductance is taken as one LSB.
         g_ff  <= (req_if.payload.series_conductance == '0) ? 31'd1
                                                           : req_if.payload.series_conductance;
         sh_ff <= req_if.payload.self_heating;
         te_ff <= req_if.payload.device_temp;
      end
      prod_ff     <= prod_in;
      fl_ff       <= fl_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      qbig_ff     <= qbig_in;
      step_ff     <= step_in;
      lim_ff      <= lim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the diode safe-area monitor with its own predictor.
module tb_top;
   import dsam_pkg::*;

   typedef enum int {
      WARN_FORWARD, WARN_REVERSE, WARN_CURRENT, WARN_POWER, WARN_TEMP
   } warn_kind_type;

   typedef enum int {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   localparam int WARN_CAP = (MAX_WARNS_DEFAULT < 7) ? MAX_WARNS_DEFAULT : 7;
   localparam int ITEMS_PER_PHASE = 186;
   localparam int HOLD_CYCLES = 400;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   dsam_stream_if #(.payload_type(req_payload_type)) req_ch ();
   dsam_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   diode_safe_area_monitor uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Copy of the limit registers and warning counters.
   longint signed   fwd_limit = 64'sh7FFF_FFFF;
   longint signed   rev_limit = 64'sh7FFF_FFFF;
   longint unsigned cur_limit = 64'h7FFF_FFFF;
   longint unsigned pwr_limit = 64'h7FFF_FFFF;
   longint signed   tmp_limit = 64'sh7FFF_FFFF;
   longint signed   nom_temp  = 0;
   longint unsigned slope     = 0;
   logic [1:0]      given     = 2'b00;
   int              warn_count [5];

   req_payload_type pending_points [$];
   rsp_payload_type expected_verdicts [$];
   idle_mode_type   idle_mode = IDLE_NONE;
   logic            rsp_hold = 1'b0;
   int              mismatch_count = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic note_violation(warn_kind_type kind, logic cond);
      if (cond && warn_count[kind] < WARN_CAP) begin
         warn_count[kind]++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_payload_type evaluate_operating_point(req_payload_type pt);
      rsp_payload_type verdict;
      longint signed   vd, cur, vj, te, prod, total;
      longint unsigned mag, g, pw, lim, diff, dec;
      logic            thermal;
      verdict = '0;
      if (pt.op == OP_CLEAR) begin
         foreach (warn_count[k]) warn_count[k] = 0;
         return verdict;
      end
      vd  = 64'($signed(pt.terminal_voltage));
      cur = 64'($signed(pt.junction_current));
      vj  = 64'($signed(pt.junction_voltage));
      te  = 64'($signed(pt.device_temp));
      g   = 64'(pt.series_conductance);
      if (g == 0) g = 1;
      mag = (cur < 0) ? -cur : cur;
      // Arithmetic shift gives the floor of the signed product over 2^16.
      prod  = cur * vj;
      total = (prod >>> 16) + $signed((mag * mag) / g);
      if (total < 0) total = -total;
      pw = (total > 64'sh7FFF_FFFF) ? 64'h7FFF_FFFF : total;
      thermal = pt.self_heating && given[0] && given[1];
      lim = pwr_limit;
      if ((thermal || (!pt.self_heating && given[0])) && te >= nom_temp) begin
         diff = te - nom_temp;
         dec  = (diff * slope) >> 16;
         lim  = (dec >= pwr_limit) ? 0 : pwr_limit - dec;
      end
      verdict.forward_warn  = note_violation(WARN_FORWARD, vd > fwd_limit);
      verdict.reverse_warn  = note_violation(WARN_REVERSE, -vd > rev_limit);
      verdict.current_warn  = note_violation(WARN_CURRENT, mag > cur_limit);
      verdict.power_warn    = note_violation(WARN_POWER, pw > lim);
      verdict.temp_warn     = thermal ? note_violation(WARN_TEMP, te > tmp_limit) : 1'b0;
      verdict.power_value   = pw[30:0];
      verdict.derated_limit = lim[30:0];
      return verdict;
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
         flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_verdict(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_verdicts.size() == 0) begin
         flag_mismatch("result item arrived with none outstanding");
         return;
      end
      want = expected_verdicts.pop_front();
      compare_field("forward_warn", 64'(got.forward_warn), 64'(want.forward_warn));
      compare_field("reverse_warn", 64'(got.reverse_warn), 64'(want.reverse_warn));
      compare_field("current_warn", 64'(got.current_warn), 64'(want.current_warn));
      compare_field("power_warn", 64'(got.power_warn), 64'(want.power_warn));
      compare_field("temp_warn", 64'(got.temp_warn), 64'(want.temp_warn));
      compare_field("power_value", 64'(got.power_value), 64'(want.power_value));
      compare_field("derated_limit", 64'(got.derated_limit), 64'(want.derated_limit));
   endtask

   function automatic bit roll(int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   // Driver: predicts on acceptance, then offers the next pending item.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_verdicts.push_back(evaluate_operating_point(req_ch.payload));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_points.size() != 0 &&
                !((idle_mode == IDLE_SENDER && roll(52)) ||
                  (idle_mode == IDLE_BOTH && roll(15)))) begin
               req_ch.valid   <= 1'b1;
               req_ch.payload <= pending_points.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result item and decides the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_verdict(rsp_ch.payload);
         rsp_ch.ready <= !rsp_hold &&
                         !((idle_mode == IDLE_RECEIVER && roll(52)) ||
                           (idle_mode == IDLE_BOTH && roll(15)));
      end
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] mag;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: begin
            mag = $urandom_range(0, 32'h0008_0000);
            return roll(50) ? -mag : mag;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            mag = $urandom() >> $urandom_range(1, 31);
            return roll(50) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [30:0] pick_conductance();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(1, 32'h7FFF_FFFF));
         1: return 31'($urandom_range(1, 32'h0002_0000));
         2: return roll(50) ? 31'h0000_0001 : 31'h7FFF_FFFF;
         default: return 31'($urandom_range(1, 32'h0000_0100));
      endcase
   endfunction

   function automatic req_payload_type make_point(logic [31:0] vd, logic [31:0] cur,
                                                  logic [31:0] vj, logic [30:0] g,
                                                  logic sh, logic [31:0] te);
      req_payload_type pt;
      pt.op                 = OP_CHECK;
      pt.terminal_voltage   = vd;
      pt.junction_current   = cur;
      pt.junction_voltage   = vj;
      pt.series_conductance = g;
      pt.self_heating       = sh;
      pt.device_temp        = te;
      return pt;
   endfunction

   function automatic req_payload_type make_random_point();
      req_payload_type pt;
      pt = make_point(pick_value(), pick_value(), pick_value(), pick_conductance(),
                      1'($urandom_range(0, 1)), pick_value());
      if ($urandom_range(0, 5) == 0) pt.op = OP_CLEAR;
      return pt;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_FORWARD_VOLT_LIMIT: fwd_limit = 64'($signed(data));
         CSR_REVERSE_VOLT_LIMIT: rev_limit = 64'($signed(data));
         CSR_CURRENT_LIMIT:      cur_limit = 64'(data[30:0]);
         CSR_POWER_LIMIT:        pwr_limit = 64'(data[30:0]);
         CSR_TEMP_LIMIT:         tmp_limit = 64'($signed(data));
         CSR_NOMINAL_TEMP:       nom_temp  = 64'($signed(data));
         CSR_DERATE_SLOPE:       slope     = 64'(data[30:0]);
         CSR_LIMITS_GIVEN:       given     = data[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_limits(logic [31:0] fwd, logic [31:0] rev, logic [31:0] cur,
                               logic [31:0] pwr, logic [31:0] tmp, logic [31:0] nom,
                               logic [31:0] slp, logic [31:0] giv);
      write_reg(CSR_FORWARD_VOLT_LIMIT, fwd);
      write_reg(CSR_REVERSE_VOLT_LIMIT, rev);
      write_reg(CSR_CURRENT_LIMIT, cur);
      write_reg(CSR_POWER_LIMIT, pwr);
      write_reg(CSR_TEMP_LIMIT, tmp);
      write_reg(CSR_NOMINAL_TEMP, nom);
      write_reg(CSR_DERATE_SLOPE, slp);
      write_reg(CSR_LIMITS_GIVEN, giv);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every item has been offered, accepted and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_points.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      foreach (warn_count[k]) warn_count[k] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // Directed part: 2 V forward, 5 V reverse, 1 A, 16 W, 100 and 25 degrees,
      // 0.5 W per degree, derating and temperature limit both enabled.
      apply_limits(32'h0002_0000, 32'h0005_0000, 32'h0001_0000, 32'h0010_0000,
                   32'h0064_0000, 32'h0019_0000, 32'h0000_8000, 32'd3);
      pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          31'd1, 1'b1, 32'h7FFF_FFFF));
      pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          31'h7FFF_FFFF, 1'b0, 32'h8000_0000));
      // A small negative product must round toward minus infinity.
      pending_points.push_back(make_point(32'd0, 32'hFFFF_FFFD, 32'd5, 31'h7FFF_FFFF,
                                          1'b0, 32'd0));
      pending_points.push_back(make_point(32'd0, 32'd0, 32'd0, 31'd1, 1'b1, 32'h0019_0000));
      pending_points.push_back(make_point(32'd0, 32'd0, 32'd0, 31'd1, 1'b1, 32'h0018_FFFF));
      pending_points.push_back(make_point(32'h0002_0000, 32'd0, 32'd0, 31'd1, 1'b0, 32'd0));
      pending_points.push_back(make_point(32'h0002_0001, 32'd0, 32'd0, 31'd1, 1'b0, 32'd0));
      pending_points.push_back(make_point(32'hFFFB_0000, 32'd0, 32'd0, 31'd1, 1'b0, 32'd0));
      pending_points.push_back(make_point(32'hFFFA_FFFF, 32'd0, 32'd0, 31'd1, 1'b0, 32'd0));
      pending_points.push_back(make_point(32'd0, 32'h0001_0000, 32'd0, 31'h0001_0000,
                                          1'b0, 32'd0));
      pending_points.push_back(make_point(32'd0, 32'hFFFE_FFFF, 32'd0, 31'h0001_0000,
                                          1'b0, 32'd0));
      pending_points.push_back(make_point(32'd0, 32'd0, 32'd0, 31'd1, 1'b1, 32'h0064_0000));
      pending_points.push_back(make_point(32'd0, 32'd0, 32'd0, 31'd1, 1'b0, 32'h7FFF_0000));
      // Repeated forward violations run the counter into its report limit.
      repeat (6)
         pending_points.push_back(make_point(32'h0003_0000, 32'd0, 32'd0, 31'd1,
                                             1'b0, 32'd0));
      pending_points.push_back('{op: OP_CLEAR, default: '1});
      pending_points.push_back(make_point(32'h0003_0000, 32'd0, 32'd0, 31'd1, 1'b0, 32'd0));
      pending_points.push_back('{op: OP_CLEAR, default: '0});

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               apply_limits(pick_value(), pick_value(), pick_value(), pick_value(),
                            pick_value(), pick_value(), pick_value(), 32'd3);
               idle_mode = IDLE_NONE;
            end
            1: begin
               apply_limits(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0,
                            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
               idle_mode = IDLE_SENDER;
            end
            2: begin
               apply_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2);
               idle_mode = IDLE_RECEIVER;
            end
            3: begin
               apply_limits(pick_value(), pick_value(), pick_value(), pick_value(),
                            pick_value(), pick_value(), pick_value(), 32'd0);
               idle_mode = IDLE_BOTH;
            end
            default: begin
               apply_limits(pick_value(), pick_value(), pick_value(), pick_value(),
                            pick_value(), pick_value(), $urandom_range(0, 32'h0002_0000),
                            32'hFFFF_FFFF);
               idle_mode = IDLE_NONE;
               rsp_hold  = 1'b1;
            end
         endcase
         repeat (ITEMS_PER_PHASE) pending_points.push_back(make_random_point());
         // Hold the result side off so that the block backs up into its input.
         if (rsp_hold) begin
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end
      end

      wait_drained();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
